// ----- src/three_address_memory_machine_unit_assert.svh -----
// Assertion macros shared by the three-address memory machine modules.
`ifndef THREE_ADDRESS_MEMORY_MACHINE_UNIT_ASSERT_SVH
`define THREE_ADDRESS_MEMORY_MACHINE_UNIT_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define TAMM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define TAMM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/tamm_pkg.sv -----
// Shared types and constants of the three-address memory machine.
package tamm_pkg;

  localparam int PC_W          = 11;
  localparam int WORD_W        = 32;
  localparam int FUNC_W        = 4;
  localparam int A_W           = 10;
  localparam int C_W           = 8;
  localparam int PROG_DEPTH    = 1024;
  localparam int MEM_DEPTH_DEF = 256;
  localparam int IN_TDATA_W    = 56;
  localparam int OUT_TDATA_W   = 48;
  localparam int CFG_TDATA_W   = 16;

  localparam logic [WORD_W-1:0] WORD_RESET = '1;

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD     = 4'd0,
    OP_MUL     = 4'd1,
    OP_SUB     = 4'd2,
    OP_COPY    = 4'd3,
    OP_LOADI   = 4'd4,
    OP_JUMP    = 4'd5,
    OP_JZ      = 4'd6,
    OP_LESS    = 4'd7,
    OP_GREATER = 4'd8,
    OP_EQUAL   = 4'd9,
    OP_DIFFER  = 4'd10,
    OP_AND     = 4'd11,
    OP_OR      = 4'd12,
    OP_PRINT   = 4'd13
  } op_t;

  // Outcome of one executed instruction.
  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              print_valid;
    logic [WORD_W-1:0] print_value;
    logic              done;
    logic              fault;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;
  } res_t;

endpackage

// ----- src/three_address_memory_machine_unit.sv -----
// Three-address memory machine: after reset a clearing pass of MEM_DEPTH
// entries sets every data word to -1, and in_tready stays low until it ends.
// From then on one instruction item can be accepted in every cycle unless
// out_tready stalls the output. The two operand words are read from the data
// memory at acceptance; once the output register is free the item executes,
// writes its result word back, updates the program counter and enters the
// output register. The last memory write is bypassed onto the read data, so
// dependent instructions may follow each other directly. The program length
// register may be written only while no item is in flight.
`include "three_address_memory_machine_unit_assert.svh"

module three_address_memory_machine_unit import tamm_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: func[3:0], operand_a[13:4], operand_b[45:14], operand_c[53:46]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: next_pc[10:0], print_value[42:11], done_res[43], fault[44]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: print_valid[0]
  output logic                   out_tuser,
  // cfg_tdata: program_length[10:0]
  input  logic                   cfg_tvalid,
  output logic                   cfg_tready,
  input  logic [CFG_TDATA_W-1:0] cfg_tdata
);

  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int FAULT_BIT = PC_W + WORD_W + 1;

  logic              in_fire, exec_fire, clr_busy;
  op_t               in_func;
  logic [WORD_W-1:0] in_a_ext, in_b_ext, in_c_ext, ex_a_ext;
  logic [AW-1:0]     raddr0, raddr1;
  logic [WORD_W-1:0] word_x, word_y;
  res_t              res;

  logic              exec_valid_r, exec_valid_nxt;
  op_t               ex_func_r;
  logic [A_W-1:0]    ex_a_r;
  logic [WORD_W-1:0] ex_b_r;
  logic [C_W-1:0]    ex_c_r;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [PC_W-1:0]   prog_len_r, prog_len_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic              out_user_r;

  always_comb begin
    in_func  = op_t'(in_tdata[3:0]);
    in_a_ext = WORD_W'(in_tdata[13:4]);
    in_b_ext = in_tdata[45:14];
    in_c_ext = WORD_W'(in_tdata[53:46]);
    raddr0   = (in_func inside {OP_JZ, OP_PRINT}) ? in_a_ext[AW-1:0] : in_b_ext[AW-1:0];
    raddr1   = in_c_ext[AW-1:0];
    ex_a_ext = WORD_W'(ex_a_r);
  end

  assign exec_fire = exec_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_busy && (!exec_valid_r || exec_fire);
  assign in_fire   = in_tvalid && in_tready;

  tamm_mem #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire),
    .raddr0   (raddr0),
    .raddr1   (raddr1),
    .rdata0   (word_x),
    .rdata1   (word_y),
    .we       (exec_fire && res.wr_en),
    .waddr    (ex_a_ext[AW-1:0]),
    .wdata    (res.wr_data),
    .clr_busy (clr_busy)
  );

  tamm_alu #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_alu (
    .valid     (exec_valid_r),
    .pc        (pc_r),
    .prog_len  (prog_len_r),
    .func      (ex_func_r),
    .operand_a (ex_a_r),
    .operand_b ($signed(ex_b_r)),
    .operand_c (ex_c_r),
    .word_x    (word_x),
    .word_y    (word_y),
    .res       (res)
  );

  always_comb begin
    exec_valid_nxt = in_fire || (exec_valid_r && !exec_fire);
    pc_nxt         = exec_fire ? res.next_pc : pc_r;
    prog_len_nxt   = (cfg_tvalid && cfg_tready) ? cfg_tdata[PC_W-1:0] : prog_len_r;
    out_valid_nxt  = exec_fire || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_valid_r <= 1'b0;
      pc_r         <= '0;
      prog_len_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      exec_valid_r <= exec_valid_nxt;
      pc_r         <= pc_nxt;
      prog_len_r   <= prog_len_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_func_r <= in_func;
      ex_a_r    <= in_tdata[13:4];
      ex_b_r    <= in_b_ext;
      ex_c_r    <= in_tdata[53:46];
    end
    if (exec_fire) begin
      out_data_r <= {3'b000, res.fault, res.done, res.print_value, res.next_pc};
      out_user_r <= res.print_valid;
    end
  end

  assign cfg_tready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `TAMM_ASSERT_NEXT(a_pc_hold, !exec_fire, $stable(pc_r), "program counter moved without an executed item")
  `TAMM_ASSERT(a_fault_no_write, exec_fire && res.fault |-> !res.wr_en, "faulting item wrote memory")
  `TAMM_ASSERT(a_print_no_fault, out_tvalid |-> !(out_tuser && out_tdata[FAULT_BIT]), "print and fault in one item")

endmodule

// ----- src/tamm_mem.sv -----
// Data memory: two registered read ports, one write port, reset clearing pass.
`include "three_address_memory_machine_unit_assert.svh"

module tamm_mem import tamm_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF,
  parameter int AW        = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     raddr0,
  input  logic [AW-1:0]     raddr1,
  output logic [WORD_W-1:0] rdata0,
  output logic [WORD_W-1:0] rdata1,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  output logic              clr_busy
);

  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

  logic [WORD_W-1:0] mem [MEM_DEPTH];

  logic              clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              fwd_valid_r, fwd_valid_nxt;
  logic [AW-1:0]     fwd_addr_r;
  logic [WORD_W-1:0] fwd_data_r;
  logic [AW-1:0]     raddr0_r, raddr1_r;
  logic [WORD_W-1:0] rdata0_r, rdata1_r;
  logic              wr_any;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  always_comb begin
    wr_any        = clr_busy_r || we;
    wr_addr       = clr_busy_r ? clr_addr_r : waddr;
    wr_data       = clr_busy_r ? WORD_RESET : wdata;
    clr_addr_nxt  = clr_busy_r ? clr_addr_r + AW'(1) : clr_addr_r;
    clr_busy_nxt  = clr_busy_r && (clr_addr_r != LAST_ADDR);
    fwd_valid_nxt = fwd_valid_r || wr_any;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      fwd_valid_r <= fwd_valid_nxt;
    end
  end

  // The last write always matches the memory, so it may bypass a read that
  // was captured in the same cycle as that write.
  always_ff @(posedge clk) begin
    if (wr_any) begin
      mem[wr_addr] <= wr_data;
      fwd_addr_r   <= wr_addr;
      fwd_data_r   <= wr_data;
    end
    if (rd_en) begin
      rdata0_r <= mem[raddr0];
      rdata1_r <= mem[raddr1];
      raddr0_r <= raddr0;
      raddr1_r <= raddr1;
    end
  end

  assign rdata0   = (fwd_valid_r && fwd_addr_r == raddr0_r) ? fwd_data_r : rdata0_r;
  assign rdata1   = (fwd_valid_r && fwd_addr_r == raddr1_r) ? fwd_data_r : rdata1_r;
  assign clr_busy = clr_busy_r;

  `TAMM_ASSERT(a_clr_no_exec_write, clr_busy_r |-> !we, "write request during clearing pass")
  `TAMM_ASSERT_NEXT(a_clr_ends, clr_busy_r && (clr_addr_r == LAST_ADDR), !clr_busy_r, "clearing pass did not end at the last entry")

endmodule

// ----- src/tamm_alu.sv -----
// Instruction execution: range checks, arithmetic, compares and next pc.
module tamm_alu import tamm_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic                     valid,
  input  logic [PC_W-1:0]          pc,
  input  logic [PC_W-1:0]          prog_len,
  input  op_t                      func,
  input  logic [A_W-1:0]           operand_a,
  input  logic signed [WORD_W-1:0] operand_b,
  input  logic [C_W-1:0]           operand_c,
  input  logic [WORD_W-1:0]        word_x,
  input  logic [WORD_W-1:0]        word_y,
  output res_t                     res
);

  logic [PC_W-1:0]   len;
  logic [WORD_W-1:0] a_ext, b_u, c_ext;
  logic              a_ok, b_ok, c_ok, halted;
  logic [WORD_W-1:0] prod;
  logic              x_nz, y_nz;

  assign prod = word_x * word_y;

  always_comb begin
    len    = (prog_len > PC_W'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH) : prog_len;
    a_ext  = WORD_W'(operand_a);
    b_u    = $unsigned(operand_b);
    c_ext  = WORD_W'(operand_c);
    a_ok   = a_ext < WORD_W'(MEM_DEPTH);
    b_ok   = b_u < WORD_W'(MEM_DEPTH);
    c_ok   = c_ext < WORD_W'(MEM_DEPTH);
    x_nz   = word_x != '0;
    y_nz   = word_y != '0;
    halted = pc >= len;

    res             = '0;
    res.next_pc     = halted ? pc : pc + PC_W'(1);

    if (valid && !halted) begin
      case (func)
        OP_ADD, OP_MUL, OP_SUB, OP_LESS, OP_GREATER, OP_EQUAL, OP_DIFFER,
        OP_AND, OP_OR: begin
          if (!(a_ok && b_ok && c_ok)) begin
            res.fault = 1'b1;
          end else begin
            res.wr_en = 1'b1;
            case (func)
              OP_ADD:     res.wr_data = word_x + word_y;
              OP_MUL:     res.wr_data = prod;
              OP_SUB:     res.wr_data = word_x - word_y;
              OP_LESS:    res.wr_data = WORD_W'($signed(word_x) < $signed(word_y));
              OP_GREATER: res.wr_data = WORD_W'($signed(word_y) < $signed(word_x));
              OP_EQUAL:   res.wr_data = WORD_W'(word_x == word_y);
              OP_DIFFER:  res.wr_data = WORD_W'(word_x != word_y);
              OP_AND:     res.wr_data = WORD_W'(x_nz && y_nz);
              default:    res.wr_data = WORD_W'(x_nz || y_nz);
            endcase
          end
        end
        OP_COPY: begin
          if (a_ok && b_ok) begin
            res.wr_en   = 1'b1;
            res.wr_data = word_x;
          end else begin
            res.fault = 1'b1;
          end
        end
        OP_LOADI: begin
          if (a_ok) begin
            res.wr_en   = 1'b1;
            res.wr_data = b_u;
          end else begin
            res.fault = 1'b1;
          end
        end
        OP_JUMP: begin
          if (a_ext <= WORD_W'(PROG_DEPTH)) res.next_pc = PC_W'(operand_a);
          else res.fault = 1'b1;
        end
        OP_JZ: begin
          // The target is only checked when the branch is taken.
          if (!a_ok) begin
            res.fault = 1'b1;
          end else if (!x_nz) begin
            if (b_u <= WORD_W'(PROG_DEPTH)) res.next_pc = b_u[PC_W-1:0];
            else res.fault = 1'b1;
          end
        end
        OP_PRINT: begin
          if (a_ok) begin
            res.print_valid = 1'b1;
            res.print_value = word_x;
          end else begin
            res.fault = 1'b1;
          end
        end
        default: ;
      endcase
    end

    res.done = res.next_pc >= len;
  end

endmodule
